>>> rtl/dgbs_pkg.sv
// shared types and constants of the depth gated bilinear sampler
package dgbs_pkg;

   localparam int DepthW = 16;
   localparam int WgtW   = 17;   // neighbour weight, up to 65536
   localparam int WsumW  = 18;   // sum of up to four weights
   localparam int AccW   = 26;   // sum of weight times intensity
   localparam int NumW   = 35;   // acc * 256 + wsum / 2
   localparam int QuoW   = 17;

   localparam logic [DepthW-1:0] ZMAX_FLOOR = 16'd100;
   localparam logic [DepthW-1:0] ZMIN_GAP   = 16'd10;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   typedef enum logic [0:0] {
      CSR_MIN_DIFF = 1'b0,
      CSR_MAX_DIFF = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // one sample handed from the gather stage to the divider
   typedef struct packed {
      logic [AccW-1:0]  acc;
      logic [WsumW-1:0] wsum;
   } div_job_type;

endpackage

>>> rtl/dgbs_if.sv
// valid/ready channel interfaces of the sampler
interface dgbs_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [9:0]  col;
   logic [8:0]  row;
   logic [7:0]  intensity;
   logic [15:0] depth_mm;
   logic [17:0] x_pos;
   logic [16:0] y_pos;
   logic [15:0] ref_depth;
   modport source (output valid, kind, col, row, intensity, depth_mm, x_pos, y_pos,
                   ref_depth, input ready);
   modport sink (input valid, kind, col, row, intensity, depth_mm, x_pos, y_pos,
                 ref_depth, output ready);
endinterface

interface dgbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;
   logic        valid_res;
   modport source (output valid, value, valid_res, input ready);
   modport sink (input valid, value, valid_res, output ready);
endinterface

interface dgbs_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/dgbs_front.sv
// front: pixel memories, window compute and four-neighbour gather
module dgbs_front
   import dgbs_pkg::*;
#(
   parameter int ImgWidth  = 640,
   parameter int ImgHeight = 480
) (
   input  logic              clock,
   input  logic              reset,
   dgbs_req_if.sink          req,
   input  logic [DepthW-1:0] min_diff,
   input  logic [DepthW-1:0] max_diff,
   output logic              job_valid,
   input  logic              job_ready,
   output div_job_type       job
);
   localparam int Pixels = ImgWidth * ImgHeight;
   localparam int AddrW  = $clog2(Pixels);
   localparam int XW     = $clog2(ImgWidth);
   localparam int YW     = $clog2(ImgHeight);
   localparam logic [XW-1:0] XLast = XW'(ImgWidth - 1);
   localparam logic [YW-1:0] YLast = YW'(ImgHeight - 1);

   logic [7:0]        int_mem [Pixels];
   logic [DepthW-1:0] dep_mem [Pixels];

   // sequencer: 0 idle, 1..4 issue neighbour reads, 5 last accumulate, 6 hand off
   logic [2:0]        step_ff, step_in;
   logic [XW-1:0]     x0_ff, x1_ff;
   logic [YW-1:0]     y0_ff, y1_ff;
   logic [7:0]        fx_ff, fy_ff;
   logic [DepthW-1:0] zmin_ff, zmax_ff;
   logic [WgtW-1:0]   w_ff;
   logic              rd_act_ff;
   logic [7:0]        rd_int_ff;
   logic [DepthW-1:0] rd_dep_ff;
   logic [AccW-1:0]   acc_ff;
   logic [WsumW-1:0]  wsum_ff;
   logic [AddrW-1:0]  rd_addr;
   logic [WgtW-1:0]   w_next;
   logic [8:0]        hx, hy;
   logic              accept;

   logic [9:0]        ix;
   logic [8:0]        iy;
   logic [XW-1:0]     x0c;
   logic [YW-1:0]     y0c;
   logic [DepthW:0]   zmax_sum, t_sub;
   logic [DepthW-1:0] zmax_c;
   logic signed [DepthW+1:0] t_s, zcap;

   assign req.ready = (step_ff == 3'd0);
   assign accept    = req.valid && req.ready;
   assign job_valid = (step_ff == 3'd6);
   assign job.acc   = acc_ff;
   assign job.wsum  = wsum_ff;

   assign ix  = req.x_pos[17:8];
   assign iy  = req.y_pos[16:8];
   assign x0c = (32'(ix) > ImgWidth - 1) ? XLast : XW'(ix);
   assign y0c = (32'(iy) > ImgHeight - 1) ? YLast : YW'(iy);

   always_comb begin
      zmax_sum = {1'b0, req.ref_depth} + {1'b0, max_diff};
      zmax_c   = zmax_sum[DepthW] ? '1 : zmax_sum[DepthW-1:0];
      if (zmax_c < ZMAX_FLOOR) zmax_c = ZMAX_FLOOR;
      t_sub = {1'b0, req.ref_depth} - {1'b0, min_diff};
      t_s   = {t_sub[DepthW], t_sub};
      zcap  = $signed({2'b00, zmax_c - ZMIN_GAP});
      if (t_s > zcap) t_s = zcap;
   end

   always_comb begin
      step_in = step_ff;
      case (step_ff)
         3'd0: if (accept && req.kind == KIND_SAMPLE) step_in = 3'd1;
         3'd6: if (job_ready) step_in = 3'd0;
         default: step_in = step_ff + 3'd1;
      endcase
   end

   always_comb begin
      hx = 9'd256 - {1'b0, fx_ff};
      hy = 9'd256 - {1'b0, fy_ff};
      case (step_ff)
         3'd1: begin rd_addr = AddrW'(y0_ff * ImgWidth + x0_ff);
            w_next = WgtW'(hx) * WgtW'(hy); end
         3'd2: begin rd_addr = AddrW'(y0_ff * ImgWidth + x1_ff);
            w_next = WgtW'(fx_ff) * WgtW'(hy); end
         3'd3: begin rd_addr = AddrW'(y1_ff * ImgWidth + x0_ff);
            w_next = WgtW'(hx) * WgtW'(fy_ff); end
         default: begin rd_addr = AddrW'(y1_ff * ImgWidth + x1_ff);
            w_next = WgtW'(fx_ff) * WgtW'(fy_ff); end
      endcase
   end

   // single-ported memories: writes when idle, reads during the gather
   always_ff @(posedge clock) begin
      if (accept && req.kind == KIND_WRITE && 32'(req.col) < ImgWidth
          && 32'(req.row) < ImgHeight) begin
         int_mem[AddrW'(req.row * ImgWidth + req.col)] <= req.intensity;
         dep_mem[AddrW'(req.row * ImgWidth + req.col)] <= req.depth_mm;
      end else begin
         rd_int_ff <= int_mem[rd_addr];
         rd_dep_ff <= dep_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= 3'd0;
         rd_act_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         rd_act_ff <= (step_ff >= 3'd1) && (step_ff <= 3'd4);
      end
      w_ff <= w_next;
      if (accept) begin
         x0_ff   <= x0c;
         y0_ff   <= y0c;
         x1_ff   <= (x0c == XLast) ? XLast : x0c + XW'(1);
         y1_ff   <= (y0c == YLast) ? YLast : y0c + YW'(1);
         fx_ff   <= req.x_pos[7:0];
         fy_ff   <= req.y_pos[7:0];
         zmax_ff <= zmax_c;
         zmin_ff <= t_s[DepthW+1] ? '0 : t_s[DepthW-1:0];
         acc_ff  <= '0;
         wsum_ff <= '0;
      end else if (rd_act_ff && rd_dep_ff > zmin_ff && rd_dep_ff < zmax_ff) begin
         acc_ff  <= acc_ff + AccW'(w_ff) * AccW'(rd_int_ff);
         wsum_ff <= wsum_ff + WsumW'(w_ff);
      end
   end
endmodule

>>> rtl/dgbs_queue.sv
// two-entry queue between gather and divider
module dgbs_queue
   import dgbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_job_type in_job,
   output logic        out_valid,
   input  logic        out_ready,
   output div_job_type out_job
);
   div_job_type slot_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = slot_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wp_ff] <= in_job;
   end
endmodule

>>> rtl/dgbs_div.sv
// back: restoring divider, one quotient bit per cycle, with output register
module dgbs_div
   import dgbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  div_job_type job,
   dgbs_rsp_if.source  rsp
);
   div_state_type     state_ff, state_in;
   logic [NumW-1:0]   num_ff;
   logic [WsumW:0]    rem_ff;
   logic [WsumW-1:0]  den_ff;
   logic [5:0]        cnt_ff;
   logic              ok_ff;
   logic [WsumW:0]    trial;
   logic [WsumW:0]    shifted;

   assign job_ready = (state_ff == DIV_IDLE);
   assign rsp.valid = (state_ff == DIV_DONE);
   // quotient fits 17 bits; max real value 65280
   assign rsp.value     = ok_ff ? num_ff[15:0] : 16'd0;
   assign rsp.valid_res = ok_ff;

   assign shifted = {rem_ff[WsumW-1:0], num_ff[NumW-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: if (job_valid) state_in = DIV_RUN;
         DIV_RUN:  if (cnt_ff == 6'd0) state_in = DIV_DONE;
         DIV_DONE: if (rsp.ready) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= DIV_IDLE;
      else state_ff <= state_in;
      if (state_ff == DIV_IDLE && job_valid) begin
         num_ff <= {1'b0, job.acc, 8'd0} + NumW'(job.wsum[WsumW-1:1]);
         den_ff <= job.wsum;
         ok_ff  <= (job.wsum != '0);
         rem_ff <= '0;
         cnt_ff <= 6'(NumW - 1);
      end else if (state_ff == DIV_RUN) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (!trial[WsumW]) begin
            rem_ff <= trial;
            num_ff <= {num_ff[NumW-2:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            num_ff <= {num_ff[NumW-2:0], 1'b0};
         end
      end
   end
endmodule

>>> rtl/depth_gated_bilinear_sampler_core.sv
// top level of the depth gated bilinear sampler
// Usage: requests arrive on req (valid/ready). kind 0 writes one pixel's
// intensity and depth into on-chip image and depth memories and gives no
// response; kind 1 samples at a Q.8 position and gives one response on rsp:
// value (Q8.8 weighted mean of neighbours inside the depth window) and
// valid_res. The csr channel writes min_depth_diff (index 0) and
// max_depth_diff (index 1); it is always ready and should be used when idle.
// A sample occupies the front for four single-port memory reads, one
// per cycle, then accumulate and hand-off. The divider works on one
// sample at a time, one quotient bit per cycle, and sets the sustained
// sample rate. A two-entry queue lets the front run ahead of the divider.
// Reset clears control state and restores both limits to 1000; memory
// contents stay undefined until written. If rsp is stalled the result holds
// in the divider output register, the queue fills and req backs up.
module depth_gated_bilinear_sampler_core
   import dgbs_pkg::*;
#(
   parameter int ImgWidth  = 640,
   parameter int ImgHeight = 480
) (
   input  logic      clock,
   input  logic      reset,
   dgbs_req_if.sink  req,
   dgbs_rsp_if.source rsp,
   dgbs_csr_if.sink  csr
);
   logic [DepthW-1:0] min_diff_ff, max_diff_ff;
   logic              f_valid, f_ready, q_valid, q_ready;
   div_job_type       f_job, q_job;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_diff_ff <= 16'd1000;
         max_diff_ff <= 16'd1000;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_MIN_DIFF: min_diff_ff <= csr.data;
            CSR_MAX_DIFF: max_diff_ff <= csr.data;
            default: ;
         endcase
      end
   end

   dgbs_front #(.ImgWidth(ImgWidth), .ImgHeight(ImgHeight)) u_front (
      .clock, .reset, .req, .min_diff(min_diff_ff), .max_diff(max_diff_ff),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

   dgbs_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job));

   dgbs_div u_div (
      .clock, .reset, .job_valid(q_valid), .job_ready(q_ready), .job(q_job), .rsp);
endmodule

>>> tb/sv/tb.sv
// testbench for the depth gated bilinear sampler core
`timescale 1ns / 100ps

module tb
   import dgbs_pkg::*;
();

   localparam int ImgW      = 640;
   localparam int ImgH      = 480;
   localparam int NumPix    = ImgW * ImgH;
   localparam int CycleMax  = 1500000;
   localparam int DrainWait = 60;
   localparam int PhaseLen  = 300;

   typedef struct {
      kind_type    kind;
      logic [9:0]  col;
      logic [8:0]  row;
      logic [7:0]  intensity;
      logic [15:0] depth_mm;
      logic [17:0] x_pos;
      logic [16:0] y_pos;
      logic [15:0] ref_depth;
      bit          typed;
      logic [15:0] typed_value;
      logic        typed_ok;
   } request_type;

   typedef struct {
      logic [15:0] value;
      logic        valid_res;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dgbs_req_if req_ch ();
   dgbs_rsp_if rsp_ch ();
   dgbs_csr_if csr_ch ();

   depth_gated_bilinear_sampler_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #5 clock = ~clock;

   // shadow image, depth map and window limits
   logic [7:0]  shadow_int [0:NumPix-1];
   logic [15:0] shadow_depth [0:NumPix-1];
   int          lim_below = 1000;
   int          lim_above = 1000;

   sample_type  pending_samples[$];
   request_type directed_rows[$];
   int       cycles = 0;
   int       mismatches = 0;
   int       n_writes = 0;
   int       n_samples = 0;
   int       n_checked = 0;
   bit       quiet = 0;
   int       stall_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic sample_type predict_sample(logic [17:0] xp, logic [16:0] yp,
                                                 logic [15:0] rd);
      int      fx, fy, x0, y0, x1, y1, zmax, zmin, t, d, a, wsum;
      int      px [4];
      int      py [4];
      int      w  [4];
      longint  acc, v;
      sample_type r;
      fx = int'(xp[7:0]);
      fy = int'(yp[7:0]);
      x0 = int'(xp[17:8]);
      y0 = int'(yp[16:8]);
      if (x0 > ImgW - 1) x0 = ImgW - 1;
      if (y0 > ImgH - 1) y0 = ImgH - 1;
      x1 = (x0 + 1 > ImgW - 1) ? ImgW - 1 : x0 + 1;
      y1 = (y0 + 1 > ImgH - 1) ? ImgH - 1 : y0 + 1;
      zmax = int'(rd) + lim_above;
      if (zmax > 65535) zmax = 65535;
      if (zmax < 100) zmax = 100;
      t = int'(rd) - lim_below;
      if (t > zmax - 10) t = zmax - 10;
      zmin = (t < 0) ? 0 : t;
      px = '{x0, x1, x0, x1};
      py = '{y0, y0, y1, y1};
      w  = '{(256 - fx) * (256 - fy), fx * (256 - fy), (256 - fx) * fy, fx * fy};
      acc = 0;
      wsum = 0;
      for (int k = 0; k < 4; k++) begin
         a = py[k] * ImgW + px[k];
         d = int'(shadow_depth[a]);
         if (zmin < d && d < zmax) begin
            acc += longint'(w[k]) * longint'(shadow_int[a]);
            wsum += w[k];
         end
      end
      if (wsum == 0) begin
         r.value = 16'd0;
         r.valid_res = 1'b0;
      end else begin
         v = (acc * 256 + wsum / 2) / wsum;
         if (v > 65535) v = 65535;
         r.value = v[15:0];
         r.valid_res = 1'b1;
      end
      return r;
   endfunction

   function automatic request_type wr(int c, int r, int i, int d);
      request_type q;
      q = '{kind: KIND_WRITE, col: 10'(c), row: 9'(r), intensity: 8'(i),
            depth_mm: 16'(d), x_pos: 18'($urandom()), y_pos: 17'($urandom()),
            ref_depth: 16'($urandom()), typed: 1'b0, typed_value: 16'd0, typed_ok: 1'b0};
      return q;
   endfunction

   function automatic request_type smp(int x, int y, int rd, bit ty, int tv, bit tok);
      request_type q;
      q = '{kind: KIND_SAMPLE, col: 10'($urandom()), row: 9'($urandom()),
            intensity: 8'($urandom()), depth_mm: 16'($urandom()), x_pos: 18'(x),
            y_pos: 17'(y), ref_depth: 16'(rd), typed: ty, typed_value: 16'(tv),
            typed_ok: tok};
      return q;
   endfunction

   function automatic logic [15:0] rand_depth();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 15) return 16'hFFFF;
      return 16'($urandom_range(200, 3000));
   endfunction

   // sample inside one of the two filled patches, neighbours always written
   function automatic request_type rand_sample();
      int       x, y, rd, r;
      request_type q;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         x = $urandom_range(0, 14) * 256 + $urandom_range(0, 255);
         y = $urandom_range(0, 14) * 256 + $urandom_range(0, 255);
      end else if (r < 85) begin
         x = $urandom_range(624, 639) * 256 + $urandom_range(0, 255);
         y = $urandom_range(464, 479) * 256 + $urandom_range(0, 255);
      end else begin
         // near and past the image edge
         x = $urandom_range(624 * 256, 18'h3FFFF);
         y = $urandom_range(464 * 256, 17'h1FFFF);
      end
      if ($urandom_range(0, 9) == 0) x = x & ~255;
      if ($urandom_range(0, 9) == 0) y = y & ~255;
      rd = ($urandom_range(0, 9) < 7) ? $urandom_range(200, 3000) : $urandom_range(0, 65535);
      q = smp(x, y, rd, 0, 0, 0);
      return q;
   endfunction

   function automatic request_type rand_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return rand_sample();
      if (r < 75)
         return wr($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
                   int'(rand_depth()));
      if (r < 90)
         return wr($urandom_range(624, 639), $urandom_range(464, 479),
                   $urandom_range(0, 255), int'(rand_depth()));
      if (r < 95)
         return wr($urandom_range(0, ImgW - 1), $urandom_range(0, ImgH - 1),
                   $urandom_range(0, 255), int'(rand_depth()));
      // outside the image, dropped by the block
      if (r < 98)
         return wr($urandom_range(ImgW, 1023), $urandom_range(0, 511), $urandom_range(0, 255),
                   $urandom_range(0, 65535));
      return wr($urandom_range(0, 1023), $urandom_range(ImgH, 511), $urandom_range(0, 255),
                $urandom_range(0, 65535));
   endfunction

   task automatic send_request(request_type q);
      int      gap;
      sample_type e;
      if ($urandom_range(0, 99) == 0) quiet = ~quiet;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.kind      = q.kind;
      req_ch.col       = q.col;
      req_ch.row       = q.row;
      req_ch.intensity = q.intensity;
      req_ch.depth_mm  = q.depth_mm;
      req_ch.x_pos     = q.x_pos;
      req_ch.y_pos     = q.y_pos;
      req_ch.ref_depth = q.ref_depth;
      req_ch.valid     = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      if (q.kind == KIND_WRITE) begin
         n_writes++;
         if (q.col < ImgW && q.row < ImgH) begin
            shadow_int[q.row * ImgW + q.col]   = q.intensity;
            shadow_depth[q.row * ImgW + q.col] = q.depth_mm;
         end
      end else begin
         n_samples++;
         if (q.typed) begin
            e.value = q.typed_value;
            e.valid_res = q.typed_ok;
         end else begin
            e = predict_sample(q.x_pos, q.y_pos, q.ref_depth);
         end
         pending_samples.push_back(e);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      csr_ch.index = idx;
      csr_ch.data  = val;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_MIN_DIFF) lim_below = int'(val);
      else lim_above = int'(val);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (DrainWait) @(negedge clock);
   endtask

   // response side stalls
   always @(negedge clock) begin
      if (!reset && stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      sample_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response value=%h valid_res=%b",
                        rsp_ch.value, rsp_ch.valid_res);
         end else begin
            e = pending_samples.pop_front();
            n_checked++;
            if (rsp_ch.value !== e.value || rsp_ch.valid_res !== e.valid_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample %0d mismatch: expected value=%h valid_res=%b, got %h %b",
                           n_checked, e.value, e.valid_res, rsp_ch.value, rsp_ch.valid_res);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleMax) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int below [4];
      int above [4];
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_WRITE;
      req_ch.col       = '0;
      req_ch.row       = '0;
      req_ch.intensity = '0;
      req_ch.depth_mm  = '0;
      req_ch.x_pos     = '0;
      req_ch.y_pos     = '0;
      req_ch.ref_depth = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_MIN_DIFF;
      csr_ch.data      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part with reset limits
      directed_rows.push_back(wr(0, 0, 255, 2000));
      directed_rows.push_back(wr(1, 0, 0, 2000));
      directed_rows.push_back(wr(0, 1, 100, 2000));
      directed_rows.push_back(wr(1, 1, 200, 2000));
      directed_rows.push_back(smp(0, 0, 2000, 1, 65280, 1));
      directed_rows.push_back(smp(128, 128, 2000, 0, 0, 0));
      directed_rows.push_back(smp(255, 255, 2000, 0, 0, 0));
      directed_rows.push_back(smp(0, 0, 0, 1, 0, 0));
      directed_rows.push_back(smp(0, 0, 65535, 1, 0, 0));
      directed_rows.push_back(wr(639, 479, 77, 65534));
      directed_rows.push_back(smp(18'h3FFFF, 17'h1FFFF, 65535, 1, 19712, 1));
      // zero depth is never inside the window
      directed_rows.push_back(wr(639, 479, 0, 0));
      directed_rows.push_back(smp(18'h3FFFF, 17'h1FFFF, 0, 1, 0, 0));
      directed_rows.push_back(wr(1023, 511, 1, 1));
      directed_rows.push_back(wr(640, 0, 1, 1));
      directed_rows.push_back(wr(0, 480, 1, 1));
      directed_rows.push_back(smp(0, 0, 2000, 1, 65280, 1));
      directed_rows.push_back(wr(639, 479, 255, 1000));
      directed_rows.push_back(smp(639 * 256, 479 * 256, 1000, 1, 65280, 1));
      directed_rows.push_back(smp(639 * 256 + 128, 479 * 256 + 200, 1000, 1, 65280, 1));
      directed_rows.push_back(smp(128, 0, 2000, 0, 0, 0));
      foreach (directed_rows[i]) send_request(directed_rows[i]);
      wait_idle();

      // fill both patches before any random sample reads them
      for (int r = 0; r < 16; r++)
         for (int c = 0; c < 16; c++) begin
            send_request(wr(c, r, $urandom_range(0, 255), int'(rand_depth())));
            send_request(wr(624 + c, 464 + r, $urandom_range(0, 255), int'(rand_depth())));
         end

      below = '{0, 65535, 300, 0};
      above = '{0, 65535, 2000, 0};
      below[3] = $urandom_range(0, 65535);
      above[3] = $urandom_range(0, 65535);
      for (int p = 0; p < 5; p++) begin
         if (p > 0) begin
            wait_idle();
            write_csr(CSR_MIN_DIFF, 16'(below[p-1]));
            write_csr(CSR_MAX_DIFF, 16'(above[p-1]));
         end
         repeat (PhaseLen - ((p == 0) ? 100 : 0)) send_request(rand_request());
      end
      req_ch.valid = 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      $display("covered %0d pixel writes and %0d samples, %0d responses checked",
               n_writes, n_samples, n_checked);
      $display("window limits swept through zero, full scale and mixed settings");
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/dgbs_pkg.sv
rtl/dgbs_if.sv
rtl/dgbs_front.sv
rtl/dgbs_queue.sv
rtl/dgbs_div.sv
rtl/depth_gated_bilinear_sampler_core.sv
tb/sv/tb.sv
